### sv/jts_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jts_pkg: shared types, constants and helpers for the JSON token scanner
// Holds the request and event layouts, character codes, scanner modes and
// the stack interface structs.
// ============================================================================
package jts_pkg;

    // Sizing
    localparam int POS_WIDTH   = 32;
    localparam int STACK_DEPTH = 64;
    localparam int SPAN_W      = 32;
    localparam int LVL_W       = 7;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int RES_MAX     = 3;
    localparam int RES_CNT_W   = 2;
    localparam int EVQ_DEPTH   = 4;
    localparam int EVQ_PTR_W   = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W   = $clog2(EVQ_DEPTH + 1);

    // Scanner modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NUMBER = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WORD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STRING = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DONE   = 3'd4;

    // Event kinds
    localparam logic [1:0] EV_TOKEN     = 2'd0;
    localparam logic [1:0] EV_CONTAINER = 2'd1;
    localparam logic [1:0] EV_ERROR     = 2'd2;
    localparam logic [1:0] EV_FINISHED  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SYNTAX   = 2'd1;
    localparam logic [1:0] ERR_MISMATCH = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Character codes
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        event_kind;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic [LVL_W-1:0]  nest_level;
        logic [1:0]        error_code;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic                 square;
        logic [POS_WIDTH-1:0] pos;
    } stk_op_t;

    typedef struct packed {
        logic [STK_LVL_W-1:0] level;
        logic                 top_square;
        logic [POS_WIDTH-1:0] top_pos;
    } stk_stat_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= CH_UP_A) && (b <= CH_UP_Z)) || ((b >= CH_LO_A) && (b <= CH_LO_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic out_item_t mk_event(input logic [1:0] kind,
                                           input logic [POS_WIDTH-1:0] s,
                                           input logic [POS_WIDTH-1:0] e,
                                           input logic [LVL_W-1:0] lvl,
                                           input logic [1:0] err);
        out_item_t r;
        r.event_kind  = kind;
        r.span_start  = SPAN_W'(s);
        r.span_end    = SPAN_W'(e);
        r.nest_level  = lvl;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

### sv/json_token_scanner_core.sv
`timescale 1ns / 1ps
// ============================================================================
// json_token_scanner_core: streaming JSON tokenizer with bracket matching
// Scans one text byte per request, reports token, container, error and
// finished events, and matches braces and brackets on an internal stack.
// ============================================================================
//
//  channel  | valid      | stall      | payload            | direction
//  ---------+------------+------------+--------------------+----------
//  bytes    | byte_valid | byte_stall | byte_req (in_item_t)  | in
//  events   | evt_valid  | evt_stall  | evt (out_item_t)      | out
//
//  Throughput: one request per cycle while the event queue drains; every
//  request yields zero to three events, and events leave one per cycle while
//  evt_stall is low, so the event port sets the rate when requests carry
//  several events. An accepted request is held in req_reg and scanned once
//  the queue has room; its events are then queued and offered in order.
//  Reset (rst_n low, async) clears position, lexer mode, errors, stack level
//  and queue; stack contents are left as they are.
//  byte_stall rises while the held request waits for queue room; evt_stall
//  holds the queue head.
//
module json_token_scanner_core
    import jts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_req,
    output logic      evt_valid,
    input  logic      evt_stall,
    output out_item_t evt
);

    in_item_t                 req_reg;
    logic                     req_vld_reg;
    logic                     fire;
    logic                     room;
    stk_op_t                  stk_op;
    stk_stat_t                stk_stat;
    out_item_t [RES_MAX-1:0]  res;
    logic [RES_CNT_W-1:0]     res_cnt;

    // Scan the held request once the queue can take its whole burst.
    assign fire       = req_vld_reg && room;
    // Hold off new requests while the held one waits.
    assign byte_stall = req_vld_reg && !fire;

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            req_reg <= byte_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            req_vld_reg <= byte_valid;
        end
    end

    jts_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (req_reg),
        .stk     (stk_stat),
        .op      (stk_op),
        .res     (res),
        .res_cnt (res_cnt)
    );

    jts_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stk_op),
        .stat  (stk_stat)
    );

    jts_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_cnt    (res_cnt),
        .wr_data   (res),
        .room      (room),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    // A stack operation is either a push or a pop, never both.
    a_stk_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stk_op.push && stk_op.pop))
        else $error("stack push and pop together");

    // The stack moves only when a request is scanned.
    a_stk_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (!stk_op.push && !stk_op.pop && (res_cnt == '0)))
        else $error("stack or queue moved without a scanned request");

    // A held request that is not scanned stays in place.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_vld_reg && !fire) |=> (req_vld_reg && $stable(req_reg)))
        else $error("held request lost");

    // The stack level never passes its depth.
    a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_stat.level <= STK_LVL_W'(STACK_DEPTH))
        else $error("stack level past depth");

endmodule

### sv/jts_stack.sv
`timescale 1ns / 1ps
// ============================================================================
// jts_stack: open-container stack
// Top entry lives in flops; the memory keeps every entry and prefetches the
// one under the top, so a pop refills the top with no wait.
// ============================================================================
module jts_stack
    import jts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  stk_op_t   op,
    output stk_stat_t stat
);

    logic [POS_WIDTH:0]     mem [STACK_DEPTH];
    logic [POS_WIDTH:0]     below_reg;
    logic [POS_WIDTH:0]     top_reg;
    logic [STK_LVL_W-1:0]   level_reg;
    logic [STK_LVL_W-1:0]   level_next;
    logic [STK_LVL_W-1:0]   rd_lvl;
    logic [IDX_W-1:0]       rd_addr;

    always_comb
    begin
        level_next = level_reg;
        if (op.push)
        begin
            level_next = level_reg + STK_LVL_W'(1);
        end
        else if (op.pop)
        begin
            level_next = level_reg - STK_LVL_W'(1);
        end
        // prefetch the entry that becomes top after the next pop
        rd_lvl  = level_next - STK_LVL_W'(2);
        rd_addr = rd_lvl[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem[level_reg[IDX_W-1:0]] <= {op.square, op.pos};
        end
        below_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            top_reg <= {op.square, op.pos};
        end
        else if (op.pop)
        begin
            top_reg <= below_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign stat.level      = level_reg;
    assign stat.top_square = top_reg[POS_WIDTH];
    assign stat.top_pos    = top_reg[POS_WIDTH-1:0];

endmodule

### sv/jts_scan.sv
`timescale 1ns / 1ps
// ============================================================================
// jts_scan: token scanner state and per-byte step logic
// Classifies one request, updates lexer state and produces up to three
// events plus at most one stack operation.
// ============================================================================
module jts_scan
    import jts_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  in_item_t                      item,
    input  stk_stat_t                     stk,
    output stk_op_t                       op,
    output out_item_t [RES_MAX-1:0]       res,
    output logic [RES_CNT_W-1:0]          res_cnt
);

    logic [POS_WIDTH-1:0] pos_reg,   pos_next;
    logic [MODE_W-1:0]    mode_reg,  mode_next;
    logic [POS_WIDTH-1:0] begin_reg, begin_next;
    logic                 dot_reg,   dot_next;
    logic                 esc_reg,   esc_next;
    logic [1:0]           err_reg,   err_next;

    always_comb
    begin
        logic [7:0]           b;
        logic [POS_WIDTH-1:0] pos_inc;
        logic                 rescan;
        logic [RES_CNT_W-1:0] n;
        stk_op_t              op_c;

        b          = item.text_byte;
        pos_inc    = pos_reg + POS_WIDTH'(1);
        rescan     = 1'b0;
        n          = '0;
        op_c       = '0;
        res        = '0;
        pos_next   = pos_reg;
        mode_next  = mode_reg;
        begin_next = begin_reg;
        dot_next   = dot_reg;
        esc_next   = esc_reg;
        err_next   = err_reg;

        if (mode_reg == MODE_DONE)
        begin
            res[n] = mk_event(EV_FINISHED, pos_reg, pos_reg, '0, ERR_NONE);
            n = n + RES_CNT_W'(1);
        end
        else if (err_reg != ERR_NONE)
        begin
            res[n] = mk_event(EV_ERROR, pos_reg, pos_reg, '0, err_reg);
            n = n + RES_CNT_W'(1);
        end
        else if (item.end_of_data)
        begin
            if ((mode_reg == MODE_NUMBER) || (mode_reg == MODE_WORD))
            begin
                res[n] = mk_event(EV_TOKEN, begin_reg, pos_reg, '0, ERR_NONE);
                n = n + RES_CNT_W'(1);
            end
            if (mode_reg == MODE_STRING)
            begin
                err_next  = ERR_SYNTAX;
                mode_next = MODE_IDLE;
                res[n] = mk_event(EV_ERROR, pos_reg, pos_reg, '0, ERR_SYNTAX);
                n = n + RES_CNT_W'(1);
            end
            else
            begin
                mode_next = MODE_DONE;
                res[n] = mk_event(EV_FINISHED, pos_reg, pos_reg, '0, ERR_NONE);
                n = n + RES_CNT_W'(1);
            end
        end
        else
        begin
            case (mode_reg)
                MODE_NUMBER:
                begin
                    if (is_digit(b) || (b == CH_UPPER_E) || (b == CH_PLUS) || (b == CH_MINUS))
                    begin
                        rescan = 1'b0;
                    end
                    else if ((b == CH_DOT) && !dot_reg)
                    begin
                        dot_next = 1'b1;
                    end
                    else
                    begin
                        res[n] = mk_event(EV_TOKEN, begin_reg, pos_reg, '0, ERR_NONE);
                        n = n + RES_CNT_W'(1);
                        mode_next = MODE_IDLE;
                        rescan = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (!is_alpha(b))
                    begin
                        res[n] = mk_event(EV_TOKEN, begin_reg, pos_reg, '0, ERR_NONE);
                        n = n + RES_CNT_W'(1);
                        mode_next = MODE_IDLE;
                        rescan = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        res[n] = mk_event(EV_TOKEN, begin_reg, pos_inc, '0, ERR_NONE);
                        n = n + RES_CNT_W'(1);
                        mode_next = MODE_IDLE;
                    end
                    else if (b == CH_NUL)
                    begin
                        err_next  = ERR_SYNTAX;
                        mode_next = MODE_IDLE;
                        res[n] = mk_event(EV_ERROR, pos_reg, pos_reg, '0, ERR_SYNTAX);
                        n = n + RES_CNT_W'(1);
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    rescan = 1'b1;
                end
            endcase

            // scan the byte as the start of a new token
            if (rescan)
            begin
                priority if (is_space(b))
                begin
                    mode_next = MODE_IDLE;
                end
                else if (is_digit(b) || (b == CH_DOT))
                begin
                    mode_next  = MODE_NUMBER;
                    begin_next = pos_reg;
                    dot_next   = (b == CH_DOT);
                end
                else if (is_alpha(b))
                begin
                    mode_next  = MODE_WORD;
                    begin_next = pos_reg;
                end
                else
                begin
                    unique case (b)
                        CH_QUOTE:
                        begin
                            mode_next  = MODE_STRING;
                            begin_next = pos_reg;
                            esc_next   = 1'b0;
                        end
                        CH_LBRACE, CH_LBRACK:
                        begin
                            if (stk.level >= STK_LVL_W'(STACK_DEPTH))
                            begin
                                err_next = ERR_OVERFLOW;
                                res[n] = mk_event(EV_ERROR, pos_reg, pos_reg, '0, ERR_OVERFLOW);
                                n = n + RES_CNT_W'(1);
                            end
                            else
                            begin
                                op_c.push   = 1'b1;
                                op_c.square = (b == CH_LBRACK);
                                op_c.pos    = pos_reg;
                                res[n] = mk_event(EV_TOKEN, pos_reg, pos_inc, '0, ERR_NONE);
                                n = n + RES_CNT_W'(1);
                            end
                        end
                        CH_RBRACE, CH_RBRACK:
                        begin
                            if ((stk.level == '0) || (stk.top_square != (b == CH_RBRACK)))
                            begin
                                err_next = ERR_MISMATCH;
                                res[n] = mk_event(EV_ERROR, pos_reg, pos_reg, '0, ERR_MISMATCH);
                                n = n + RES_CNT_W'(1);
                            end
                            else
                            begin
                                op_c.pop = 1'b1;
                                res[n] = mk_event(EV_CONTAINER, stk.top_pos, pos_inc,
                                                  LVL_W'(stk.level), ERR_NONE);
                                n = n + RES_CNT_W'(1);
                                res[n] = mk_event(EV_TOKEN, pos_reg, pos_inc, '0, ERR_NONE);
                                n = n + RES_CNT_W'(1);
                            end
                        end
                        CH_COMMA, CH_COLON:
                        begin
                            res[n] = mk_event(EV_TOKEN, pos_reg, pos_inc, '0, ERR_NONE);
                            n = n + RES_CNT_W'(1);
                        end
                        default:
                        begin
                            err_next = ERR_SYNTAX;
                            res[n] = mk_event(EV_ERROR, pos_reg, pos_reg, '0, ERR_SYNTAX);
                            n = n + RES_CNT_W'(1);
                        end
                    endcase
                end
            end
            pos_next = pos_inc;
        end

        if (n != '0)
        begin
            res[n - RES_CNT_W'(1)].last_of_run = 1'b1;
        end

        op      = fire ? op_c : '0;
        res_cnt = fire ? n : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            mode_reg  <= MODE_IDLE;
            begin_reg <= '0;
            dot_reg   <= 1'b0;
            esc_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            dot_reg   <= dot_next;
            esc_reg   <= esc_next;
            err_reg   <= err_next;
        end
    end

endmodule

### sv/jts_evq.sv
`timescale 1ns / 1ps
// ============================================================================
// jts_evq: event queue; takes up to three events per cycle, in order,
// and hands out one per cycle while evt_stall is low.
// ============================================================================
module jts_evq
    import jts_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [RES_CNT_W-1:0]    wr_cnt,
    input  out_item_t [RES_MAX-1:0] wr_data,
    output logic                    room,
    output logic                    evt_valid,
    input  logic                    evt_stall,
    output out_item_t               evt
);

    out_item_t             q_reg [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [EVQ_CNT_W-1:0]  cnt_reg;
    logic                  pop;

    assign evt_valid = (cnt_reg != '0);
    assign evt       = q_reg[rd_ptr_reg];
    assign pop       = evt_valid && !evt_stall;
    // room for a full burst of events from one request
    assign room      = (cnt_reg <= EVQ_CNT_W'(EVQ_DEPTH - RES_MAX));

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (RES_CNT_W'(i) < wr_cnt)
            begin
                q_reg[wr_ptr_reg + EVQ_PTR_W'(i)] <= wr_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + EVQ_PTR_W'(wr_cnt);
            rd_ptr_reg <= rd_ptr_reg + EVQ_PTR_W'(pop);
            cnt_reg    <= cnt_reg + EVQ_CNT_W'(wr_cnt) - EVQ_CNT_W'(pop);
        end
    end

endmodule
